### rtl/core/sgvm_pkg.sv
// Package for the species-grouped vector mean block.
// Holds sizes, group and species codes, and the request, command and divider structs.
// No dependencies.
package sgvm_pkg;

  // sizing
  localparam int MAX_ATOMS = 65536;
  localparam int COMP_W    = 16;
  localparam int SPECIES_W = 8;
  localparam int COUNT_W   = $clog2(MAX_ATOMS + 1);
  localparam int SUM_W     = COMP_W + COUNT_W;
  localparam int MAG_W     = SUM_W - 1;
  localparam int QMAG_W    = COMP_W + 1;
  localparam int STEP_W    = $clog2(MAG_W);
  localparam int GROUPS    = 3;
  localparam int AXES      = 3;
  localparam int SEL_W     = $clog2(GROUPS * AXES);

  // command queue (depth is a power of two)
  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  // group codes on the result
  localparam logic [1:0] GRP_ALL = 2'd0;
  localparam logic [1:0] GRP_S0  = 2'd1;
  localparam logic [1:0] GRP_S1  = 2'd2;

  localparam logic [1:0] AXIS_LAST = 2'(AXES - 1);

  // species codes
  localparam logic [SPECIES_W-1:0] SPECIES_FIRST  = 8'd0;
  localparam logic [SPECIES_W-1:0] SPECIES_SECOND = 8'd1;

  typedef struct packed {
    logic                     carries_atom;
    logic [SPECIES_W-1:0]     species_code;
    logic signed [COMP_W-1:0] x_component;
    logic signed [COMP_W-1:0] y_component;
    logic signed [COMP_W-1:0] z_component;
    logic                     end_of_set;
  } atom_t;

  typedef struct packed {
    logic [1:0]               group;
    logic signed [COMP_W-1:0] mean_x;
    logic signed [COMP_W-1:0] mean_y;
    logic signed [COMP_W-1:0] mean_z;
    logic                     last_of_run;
  } mean_t;

  // classified request as held in the queue
  typedef struct packed {
    logic                     add_all;
    logic                     add_s0;
    logic                     add_s1;
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
    logic                     closes;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [COUNT_W-1:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [COMP_W-1:0] quotient;
  } div_rsp_t;

endpackage

### rtl/core/sgvm_front.sv
// Front end: takes requests, tracks the set's atom count for the overflow drop
// and turns each request into a queue command. Uses sgvm_pkg.
module sgvm_front (
  input  logic            clk,
  input  logic            rst,
  input  sgvm_pkg::atom_t atom,
  input  logic            atom_valid,
  output logic            atom_ready,
  input  sgvm_pkg::qstat_t qstat,
  output logic            push,
  output sgvm_pkg::cmd_t  cmd
);

  logic [sgvm_pkg::COUNT_W-1:0] count;
  logic [sgvm_pkg::COUNT_W-1:0] count_next;
  logic accept;
  logic room;
  logic take;

  assign atom_ready = !qstat.full;
  assign accept     = atom_valid && atom_ready;
  assign room       = count < sgvm_pkg::COUNT_W'(sgvm_pkg::MAX_ATOMS);
  assign take       = atom.carries_atom && room;

  always_comb begin
    cmd.add_all = take;
    cmd.add_s0  = take && (atom.species_code == sgvm_pkg::SPECIES_FIRST);
    cmd.add_s1  = take && (atom.species_code == sgvm_pkg::SPECIES_SECOND);
    cmd.x       = atom.x_component;
    cmd.y       = atom.y_component;
    cmd.z       = atom.z_component;
    cmd.closes  = atom.end_of_set;
  end

  // requests with neither an atom taken nor a close do nothing downstream
  assign push = accept && (take || atom.end_of_set);

  always_comb begin
    count_next = count;
    if (accept) begin
      if (atom.end_of_set) begin
        count_next = '0;
      end else if (take) begin
        count_next = count + sgvm_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

### rtl/core/sgvm_queue.sv
// Short command FIFO between front and back end.
// Uses sgvm_pkg for the command struct and depth.
module sgvm_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sgvm_pkg::cmd_t   wr_cmd,
  input  logic             pop,
  output sgvm_pkg::cmd_t   head,
  output sgvm_pkg::qstat_t qstat
);

  sgvm_pkg::cmd_t               mem [sgvm_pkg::Q_DEPTH];
  logic [sgvm_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [sgvm_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [sgvm_pkg::Q_CNT_W-1:0] fill;

  assign qstat.full  = fill == sgvm_pkg::Q_CNT_W'(sgvm_pkg::Q_DEPTH);
  assign qstat.empty = fill == '0;
  assign head        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + sgvm_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + sgvm_pkg::Q_PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + sgvm_pkg::Q_CNT_W'(1);
        2'b01:   fill <= fill - sgvm_pkg::Q_CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

### rtl/core/sgvm_div.sv
// Shared signed divider, restoring, one quotient bit per cycle, truncating toward zero.
// A zero divisor yields zero. Uses sgvm_pkg for widths and structs.
module sgvm_div (
  input  logic               clk,
  input  logic               rst,
  input  sgvm_pkg::div_req_t req,
  output sgvm_pkg::div_rsp_t rsp
);

  logic                          busy;
  logic                          done;
  logic                          neg;
  logic                          zero;
  logic [sgvm_pkg::STEP_W-1:0]   step;
  logic [sgvm_pkg::COUNT_W-1:0]  dvs;
  logic [sgvm_pkg::COUNT_W-1:0]  rem;
  logic [sgvm_pkg::MAG_W-1:0]    q;

  logic [sgvm_pkg::SUM_W-1:0]    dv_u;
  logic [sgvm_pkg::SUM_W-1:0]    dv_neg;
  logic [sgvm_pkg::MAG_W-1:0]    mag;
  logic [sgvm_pkg::COUNT_W:0]    shifted;
  logic [sgvm_pkg::COUNT_W+1:0]  diff;
  logic                          fits;
  logic [sgvm_pkg::QMAG_W-1:0]   qmag;
  logic [sgvm_pkg::QMAG_W-1:0]   qneg;

  assign dv_u   = req.dividend;
  assign dv_neg = sgvm_pkg::SUM_W'(0) - dv_u;
  assign mag    = dv_u[sgvm_pkg::SUM_W-1] ? dv_neg[sgvm_pkg::MAG_W-1:0]
                                          : dv_u[sgvm_pkg::MAG_W-1:0];

  assign shifted = {rem, q[sgvm_pkg::MAG_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs};
  assign fits    = !diff[sgvm_pkg::COUNT_W+1];

  assign qmag = q[sgvm_pkg::QMAG_W-1:0];
  assign qneg = sgvm_pkg::QMAG_W'(0) - qmag;

  assign rsp.done     = done;
  assign rsp.quotient = zero ? '0
                      : (neg ? qneg[sgvm_pkg::COMP_W-1:0] : qmag[sgvm_pkg::COMP_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        q    <= mag;
        rem  <= '0;
        dvs  <= req.divisor;
        neg  <= dv_u[sgvm_pkg::SUM_W-1];
        zero <= req.divisor == '0;
      end else if (busy) begin
        rem  <= fits ? diff[sgvm_pkg::COUNT_W-1:0] : shifted[sgvm_pkg::COUNT_W-1:0];
        q    <= {q[sgvm_pkg::MAG_W-2:0], fits};
        step <= step + sgvm_pkg::STEP_W'(1);
        if (step == sgvm_pkg::STEP_W'(sgvm_pkg::MAG_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/sgvm_back.sv
// Back end: applies queued commands to the group sums and counts, and on a close
// runs nine divisions and emits three results. Uses sgvm_pkg.
module sgvm_back (
  input  logic               clk,
  input  logic               rst,
  input  sgvm_pkg::cmd_t     head,
  input  sgvm_pkg::qstat_t   qstat,
  output logic               pop,
  output sgvm_pkg::div_req_t dreq,
  input  sgvm_pkg::div_rsp_t drsp,
  output sgvm_pkg::mean_t    mean,
  output logic               mean_valid,
  input  logic               mean_ready
);

  typedef enum logic [3:0] {
    ST_RUN   = 4'b0001,
    ST_START = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t                               state;
  logic signed [sgvm_pkg::SUM_W-1:0]    sums [sgvm_pkg::GROUPS * sgvm_pkg::AXES];
  logic [sgvm_pkg::COUNT_W-1:0]         cnt  [sgvm_pkg::GROUPS];
  logic signed [sgvm_pkg::COMP_W-1:0]   res  [sgvm_pkg::AXES];
  logic [sgvm_pkg::SEL_W-1:0]           sel;
  logic [1:0]                           axis;
  logic [1:0]                           grp;
  logic signed [sgvm_pkg::SUM_W-1:0]    vec  [sgvm_pkg::AXES];
  logic                                 out_free;
  logic                                 emit;

  localparam int EXT_W = sgvm_pkg::SUM_W - sgvm_pkg::COMP_W;

  assign vec[0] = {{EXT_W{head.x[sgvm_pkg::COMP_W-1]}}, head.x};
  assign vec[1] = {{EXT_W{head.y[sgvm_pkg::COMP_W-1]}}, head.y};
  assign vec[2] = {{EXT_W{head.z[sgvm_pkg::COMP_W-1]}}, head.z};

  assign pop      = (state == ST_RUN) && !qstat.empty;
  assign out_free = !mean_valid || mean_ready;
  assign emit     = (state == ST_EMIT) && out_free;

  assign dreq.start    = state == ST_START;
  assign dreq.dividend = sums[sel];
  assign dreq.divisor  = cnt[grp];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_RUN;
      mean_valid <= 1'b0;
      sel        <= '0;
      axis       <= '0;
      grp        <= sgvm_pkg::GRP_ALL;
      for (int i = 0; i < sgvm_pkg::GROUPS * sgvm_pkg::AXES; i++) begin
        sums[i] <= '0;
      end
      for (int g = 0; g < sgvm_pkg::GROUPS; g++) begin
        cnt[g] <= '0;
      end
    end else begin
      if (emit) begin
        mean_valid <= 1'b1;
      end else if (mean_ready) begin
        mean_valid <= 1'b0;
      end
      unique case (state)
        ST_RUN: begin
          if (pop) begin
            if (head.add_all) begin
              for (int a = 0; a < sgvm_pkg::AXES; a++) begin
                sums[a] <= sums[a] + vec[a];
              end
              cnt[0] <= cnt[0] + sgvm_pkg::COUNT_W'(1);
            end
            if (head.add_s0) begin
              for (int a = 0; a < sgvm_pkg::AXES; a++) begin
                sums[sgvm_pkg::AXES + a] <= sums[sgvm_pkg::AXES + a] + vec[a];
              end
              cnt[1] <= cnt[1] + sgvm_pkg::COUNT_W'(1);
            end
            if (head.add_s1) begin
              for (int a = 0; a < sgvm_pkg::AXES; a++) begin
                sums[2 * sgvm_pkg::AXES + a] <= sums[2 * sgvm_pkg::AXES + a] + vec[a];
              end
              cnt[2] <= cnt[2] + sgvm_pkg::COUNT_W'(1);
            end
            if (head.closes) begin
              state <= ST_START;
              sel   <= '0;
              axis  <= '0;
              grp   <= sgvm_pkg::GRP_ALL;
            end
          end
        end
        ST_START: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (drsp.done) begin
            res[axis] <= drsp.quotient;
            sel       <= sel + sgvm_pkg::SEL_W'(1);
            if (axis == sgvm_pkg::AXIS_LAST) begin
              state <= ST_EMIT;
            end else begin
              axis  <= axis + 2'd1;
              state <= ST_START;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            mean.group       <= grp;
            mean.mean_x      <= res[0];
            mean.mean_y      <= res[1];
            mean.mean_z      <= res[2];
            mean.last_of_run <= grp == sgvm_pkg::GRP_S1;
            if (grp == sgvm_pkg::GRP_S1) begin
              for (int i = 0; i < sgvm_pkg::GROUPS * sgvm_pkg::AXES; i++) begin
                sums[i] <= '0;
              end
              for (int g = 0; g < sgvm_pkg::GROUPS; g++) begin
                cnt[g] <= '0;
              end
              state <= ST_RUN;
            end else begin
              grp   <= grp + 2'd1;
              axis  <= '0;
              state <= ST_START;
            end
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

endmodule

### rtl/core/species_grouped_vector_mean.sv
// Species-grouped vector mean. Each request carries at most one atom (species code
// plus x, y, z moments in signed Q1.15) and may close the set. Atoms are summed per
// component for three groups: all atoms, species 0 and species 1; other species add
// to the all-atoms group only, and atoms beyond MAX_ATOMS in one set are dropped.
// A closing request first takes its own atom, then yields three results in the
// order all, species 0, species 1, each holding sum / count truncated toward zero
// (zeros for an empty group), the last one flagged by last_of_run; sums and counts
// then clear. Rate: atoms are taken one per cycle while the command queue has room.
// A close runs the nine divisions one after another on the single restoring divider,
// which produces one quotient bit per cycle over a 32-bit magnitude; during that
// time a four-entry command queue keeps taking requests until it fills.
// Uses sgvm_pkg, sgvm_front, sgvm_queue, sgvm_div, sgvm_back.
module species_grouped_vector_mean (
  input  logic            clk,
  input  logic            rst,
  input  sgvm_pkg::atom_t atom,
  input  logic            atom_valid,
  output logic            atom_ready,
  output sgvm_pkg::mean_t mean,
  output logic            mean_valid,
  input  logic            mean_ready
);

  // front to queue
  logic               push;
  sgvm_pkg::cmd_t     wr_cmd;
  sgvm_pkg::qstat_t   qstat;

  // queue to back
  logic               pop;
  sgvm_pkg::cmd_t     head;

  // back to divider
  sgvm_pkg::div_req_t dreq;
  sgvm_pkg::div_rsp_t drsp;

  // classifies each request and decides whether the atom still fits in the set
  sgvm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .atom       (atom),
    .atom_valid (atom_valid),
    .atom_ready (atom_ready),
    .qstat      (qstat),
    .push       (push),
    .cmd        (wr_cmd)
  );

  // decouples request intake from accumulation and division
  sgvm_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .head   (head),
    .qstat  (qstat)
  );

  // one shared divider for all nine means
  sgvm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // accumulators, division sequencing and the result register
  sgvm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .qstat      (qstat),
    .pop        (pop),
    .dreq       (dreq),
    .drsp       (drsp),
    .mean       (mean),
    .mean_valid (mean_valid),
    .mean_ready (mean_ready)
  );

  // the front must never write into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("command written into full queue");

  // the back end must never read an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("command read from empty queue");

  // only the species-1 result closes a run
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    mean_valid |-> (mean.last_of_run == (mean.group == sgvm_pkg::GRP_S1)))
    else $error("last_of_run does not match group");

endmodule

### verif/tb_species_grouped_vector_mean.sv
// Self-checking testbench for species_grouped_vector_mean.
// Drives atom requests from a pending queue, predicts the three group means per set
// and checks every result. Depends on sgvm_pkg and the block itself.
module tb_species_grouped_vector_mean;
  import sgvm_pkg::*;

  localparam int RANDOM_ITEMS   = 260;
  localparam int HOLD_AFTER     = 30;      // requests taken before the long sink hold-off
  localparam int HOLD_CYCLES    = 1500;
  localparam int DRAIN_CYCLES   = 400;
  localparam int TIMEOUT_CYCLES = 500000;
  localparam int REPORT_LIMIT   = 40;
  localparam int MOST_NEG       = -32768;
  localparam int MOST_POS       = 32767;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  atom_t atom = '0;
  logic  atom_valid = 1'b0;
  logic  atom_ready;
  mean_t mean;
  logic  mean_valid;
  logic  mean_ready = 1'b0;

  species_grouped_vector_mean dut (
    .clk       (clk),
    .rst       (rst),
    .atom      (atom),
    .atom_valid(atom_valid),
    .atom_ready(atom_ready),
    .mean      (mean),
    .mean_valid(mean_valid),
    .mean_ready(mean_ready)
  );

  // pending requests and the means they are expected to produce
  atom_t atom_queue[$];
  mean_t expected_means[$];

  // predictor state: sums and atom counts per group, indexed by group code
  // (GRP_ALL, GRP_S0, GRP_S1 are 0, 1, 2)
  logic signed [SUM_W-1:0] moment_sum [GROUPS][AXES];
  logic [COUNT_W-1:0]      group_atoms [GROUPS];

  int   mismatches     = 0;
  int   requests_taken = 0;
  int   popped         = 0;
  int   calm_from      = 0;    // index of the first request of the idle-free tail
  int   src_gap        = 0;
  int   sink_gap       = 0;
  logic calm           = 1'b0;
  logic hold_off       = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  task automatic clear_sums();
    for (int g = 0; g < GROUPS; g++) begin
      group_atoms[g] = '0;
      for (int a = 0; a < AXES; a++) moment_sum[g][a] = '0;
    end
  endtask

  function automatic logic signed [COMP_W-1:0] group_mean(logic signed [SUM_W-1:0] s,
                                                          logic [COUNT_W-1:0] n);
    longint q;
    if (n == '0) return '0;
    // SV integer division truncates toward zero, as the block must
    q = longint'(s) / longint'(n);
    return q[COMP_W-1:0];
  endfunction

  task automatic add_moment(int g, atom_t a);
    moment_sum[g][0] = moment_sum[g][0] + SUM_W'(a.x_component);
    moment_sum[g][1] = moment_sum[g][1] + SUM_W'(a.y_component);
    moment_sum[g][2] = moment_sum[g][2] + SUM_W'(a.z_component);
    group_atoms[g]   = group_atoms[g] + 1'b1;
  endtask

  // take one accepted request; a close pushes three means and clears the sums
  task automatic predict_request(atom_t a);
    mean_t m;
    // atoms past the set limit are dropped outright
    if (a.carries_atom && group_atoms[GRP_ALL] < MAX_ATOMS) begin
      add_moment(GRP_ALL, a);
      if (a.species_code == SPECIES_FIRST) add_moment(GRP_S0, a);
      else if (a.species_code == SPECIES_SECOND) add_moment(GRP_S1, a);
    end
    if (a.end_of_set) begin
      for (int g = 0; g < GROUPS; g++) begin
        m.group       = 2'(g);
        m.mean_x      = group_mean(moment_sum[g][0], group_atoms[g]);
        m.mean_y      = group_mean(moment_sum[g][1], group_atoms[g]);
        m.mean_z      = group_mean(moment_sum[g][2], group_atoms[g]);
        m.last_of_run = (g == GROUPS - 1);
        expected_means.push_back(m);
      end
      clear_sums();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_item(bit carries, int species, int x, int y, int z, bit closes);
    atom_t a;
    a.carries_atom = carries;
    a.species_code = species[SPECIES_W-1:0];
    a.x_component  = x[COMP_W-1:0];
    a.y_component  = y[COMP_W-1:0];
    a.z_component  = z[COMP_W-1:0];
    a.end_of_set   = closes;
    atom_queue.push_back(a);
  endtask

  function automatic int rand_component();
    case ($urandom_range(0, 11))
      0:       return MOST_NEG;
      1:       return MOST_POS;
      2:       return $urandom_range(0, 1) ? -1 : 0;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic int rand_species();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return SPECIES_FIRST;
    if (r < 7) return SPECIES_SECOND;
    return $urandom_range(0, 255);
  endfunction

  // one well-formed set of random length, with stray no-op requests mixed in;
  // returns the number of requests that matter
  task automatic push_random_set(output int counted);
    int n;
    n = $urandom_range(0, 5) == 0 ? $urandom_range(0, 30) : $urandom_range(0, 10);
    counted = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        push_item(1'b0, $urandom_range(0, 255), rand_component(), rand_component(),
                  rand_component(), 1'b0);
      push_item(1'b1, rand_species(), rand_component(), rand_component(),
                rand_component(), 1'b0);
      counted++;
    end
    // close either on an atom of its own or on a bare request with junk fields
    push_item(1'($urandom_range(0, 1)), rand_species(), rand_component(),
              rand_component(), rand_component(), 1'b1);
    counted++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the pending queue, predicts at acceptance, idles in bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_atoms
    if (rst) begin
      atom_valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (atom_valid && atom_ready) begin
        predict_request(atom);
        requests_taken++;
      end
      // payload only moves on when the slot is free, so valid never drops unaccepted
      if (!atom_valid || atom_ready) begin
        if (src_gap > 0) begin
          src_gap--;
          atom_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          src_gap = $urandom_range(0, 3);
          atom_valid <= 1'b0;
        end else if (atom_queue.size() > 0) begin
          atom       <= atom_queue.pop_front();
          atom_valid <= 1'b1;
          popped++;
          if (popped > calm_from) calm <= 1'b1;
        end else begin
          atom_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes results, compares each field with the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic compare_field(string name, logic signed [31:0] want,
                               logic signed [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch_means
    mean_t want;
    if (rst) begin
      mean_ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (mean_valid && mean_ready) begin
        if (expected_means.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: unexpected result, expected none, actual group %0d mean %0d %0d %0d",
                     $time, mean.group, mean.mean_x, mean.mean_y, mean.mean_z);
        end else begin
          want = expected_means.pop_front();
          compare_field("group", want.group, mean.group);
          compare_field("mean_x", want.mean_x, mean.mean_x);
          compare_field("mean_y", want.mean_y, mean.mean_y);
          compare_field("mean_z", want.mean_z, mean.mean_z);
          compare_field("last_of_run", want.last_of_run, mean.last_of_run);
        end
      end
      if (hold_off) begin
        mean_ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        mean_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        sink_gap = $urandom_range(0, 3);
        mean_ready <= 1'b0;
      end else begin
        mean_ready <= 1'b1;
      end
    end
  end

  // long sink stall once traffic is flowing: the command queue fills and
  // atom_ready must drop while requests keep being offered
  initial begin : sink_hold_off
    while (requests_taken < HOLD_AFTER) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : run_sets
    int taken;
    int counted;
    taken = 0;
    clear_sums();

    // empty set on a bare close whose junk fields must be ignored
    push_item(1'b0, 8'hA5, MOST_POS, MOST_NEG, -1, 1'b1);
    // mixed set: both species, other codes, a stray no-op, close carrying an atom
    push_item(1'b1, SPECIES_FIRST, MOST_POS, MOST_NEG, 0, 1'b0);
    push_item(1'b1, SPECIES_SECOND, MOST_NEG, MOST_POS, -1, 1'b0);
    push_item(1'b0, 8'hFF, -1, -1, -1, 1'b0);
    push_item(1'b1, 7, 1, 1, 1, 1'b0);
    push_item(1'b1, 255, MOST_NEG, MOST_NEG, MOST_NEG, 1'b0);
    push_item(1'b1, 2, -1, 0, 1, 1'b0);
    push_item(1'b1, SPECIES_FIRST, -5, 3, MOST_POS, 1'b1);
    // species 0 left empty
    push_item(1'b1, SPECIES_SECOND, 3, -3, 7, 1'b0);
    push_item(1'b1, SPECIES_SECOND, 4, -4, 0, 1'b0);
    push_item(1'b0, SPECIES_FIRST, 0, 0, 0, 1'b1);
    // truncation toward zero on both signs
    push_item(1'b1, SPECIES_FIRST, -3, 3, -1, 1'b0);
    push_item(1'b1, SPECIES_FIRST, -2, 2, 0, 1'b0);
    push_item(1'b1, SPECIES_SECOND, 5, -5, 1, 1'b0);
    push_item(1'b1, SPECIES_SECOND, 2, -2, 0, 1'b0);
    push_item(1'b1, SPECIES_SECOND, 0, 0, 0, 1'b0);
    push_item(1'b0, SPECIES_FIRST, MOST_POS, MOST_POS, MOST_POS, 1'b1);
    // one-atom set closed by that atom, then another empty set
    push_item(1'b1, SPECIES_SECOND, MOST_NEG, MOST_POS, -1, 1'b1);
    push_item(1'b0, SPECIES_SECOND, 0, 0, 0, 1'b1);

    while (taken < RANDOM_ITEMS) begin
      push_random_set(counted);
      taken += counted;
    end

    // idle-free tail: a few ordinary sets
    calm_from = atom_queue.size();
    repeat (3) push_random_set(counted);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (atom_queue.size() != 0 || atom_valid || expected_means.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("** species_grouped_vector_mean: PASSED **");
    end else begin
      $display("** species_grouped_vector_mean: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 8);
    $display("%0t: timeout with %0d results outstanding", $time, expected_means.size());
    $display("** species_grouped_vector_mean: FAILED **");
    $finish;
  end

endmodule

### sim.f
rtl/core/sgvm_pkg.sv
rtl/core/sgvm_front.sv
rtl/core/sgvm_queue.sv
rtl/core/sgvm_div.sv
rtl/core/sgvm_back.sv
rtl/core/species_grouped_vector_mean.sv
verif/tb_species_grouped_vector_mean.sv
